### sv/lphd_pkg.sv
// Shared constants, types and the home-slot function of the linear-probe dictionary.
`default_nettype none
package lphd_pkg;

   localparam int SLOT_COUNT = 26;
   localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
   localparam int KEY_BITS   = 64;
   localparam int VALUE_BITS = 64;
   localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [SLOT_BITS-1:0] slot_type;

   localparam slot_type LAST_SLOT = slot_type'(SLOT_COUNT - 1);

   // request codes
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_SEARCH = 2'd1;
   localparam logic [1:0] REQ_DELETE = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   // data bit index of replace_mode within register 0; the mode sits in data bit 0
   localparam int CSR_REPLACE_MODE = 0;

   localparam logic [7:0] LOWER_A      = 8'd97;
   localparam logic [7:0] UPPER_A      = 8'd65;
   localparam logic [7:0] LETTER_COUNT = 8'd26;
   // floor(c/26) == (c*79) >> 11 for every 8-bit c
   localparam logic [14:0] RECIP_26    = 15'd79;
   localparam int          RECIP_SHIFT = 11;

   typedef struct packed {
      logic                  we;
      slot_type              waddr;
      logic [ENTRY_BITS-1:0] wdata;
      slot_type              raddr;
   } ram_port_type;

   function automatic slot_type home_of(input logic [7:0] c);
      logic [14:0] prod;
      logic [7:0]  quot;
      logic [7:0]  rem;
      prod = 15'(c) * RECIP_26;
      quot = 8'(prod >> RECIP_SHIFT);
      rem  = c - 8'(quot * LETTER_COUNT);
      if (c >= LOWER_A && c < LOWER_A + LETTER_COUNT) begin
         home_of = slot_type'(c - LOWER_A);
      end else if (c >= UPPER_A && c < UPPER_A + LETTER_COUNT) begin
         home_of = slot_type'(c - UPPER_A);
      end else begin
         home_of = slot_type'(rem);
      end
   endfunction

   function automatic slot_type next_slot(input slot_type s);
      next_slot = (s == LAST_SLOT) ? '0 : slot_type'(s + 1'b1);
   endfunction

endpackage
`default_nettype wire

### sv/lphd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module lphd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

### sv/lphd_ctrl.sv
// Probe sequencer: slot occupancy bits, insert/search/delete scans and the response register.
`default_nettype none
module lphd_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             replace_mode,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_type,
   input  wire logic [lphd_pkg::KEY_BITS-1:0]    req_key,
   input  wire logic [lphd_pkg::VALUE_BITS-1:0]  req_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [1:0]                            rsp_status,
   output logic [lphd_pkg::VALUE_BITS-1:0]       rsp_found_value,
   output logic [lphd_pkg::SLOT_BITS-1:0]        rsp_slot_index,
   output lphd_pkg::ram_port_type                ram_port,
   input  wire logic [lphd_pkg::ENTRY_BITS-1:0]  ram_rdata
);
   import lphd_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ICHK = 3'd1;
   localparam logic [2:0] S_FREE = 3'd2;
   localparam logic [2:0] S_SRCH = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   localparam slot_type DISP_LAST = slot_type'(SLOT_COUNT - 2);
   localparam slot_type SCAN_END  = slot_type'(SLOT_COUNT);

   logic [2:0]            state_ff, state_in;
   logic [1:0]            op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   slot_type              home_ff, home_in;
   slot_type              slot_ff, slot_in;
   slot_type              cnt_ff, cnt_in;
   logic                  disp_ff, disp_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   slot_type              cmp_slot_ff, cmp_slot_in;
   logic                  cmp_used_ff, cmp_used_in;
   logic                  cmp_last_ff, cmp_last_in;
   logic [SLOT_COUNT-1:0] used_ff, used_in;
   logic [1:0]            res_status_ff, res_status_in;
   logic [VALUE_BITS-1:0] res_value_ff, res_value_in;
   slot_type              res_idx_ff, res_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   slot_type              rsp_idx_ff, rsp_idx_in;

   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   slot_type              req_home;
   slot_type              rd_home;
   logic                  issuing;

   assign rd_key   = ram_rdata[ENTRY_BITS-1 -: KEY_BITS];
   assign rd_val   = ram_rdata[VALUE_BITS-1:0];
   assign req_home = home_of(req_key[KEY_BITS-1 -: 8]);
   assign rd_home  = home_of(rd_key[KEY_BITS-1 -: 8]);
   assign issuing  = (cnt_ff != SCAN_END);

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;
   assign rsp_slot_index  = rsp_idx_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      home_in       = home_ff;
      slot_in       = slot_ff;
      cnt_in        = cnt_ff;
      disp_in       = disp_ff;
      cmp_valid_in  = 1'b0;
      cmp_slot_in   = cmp_slot_ff;
      cmp_used_in   = cmp_used_ff;
      cmp_last_in   = cmp_last_ff;
      used_in       = used_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_idx_in    = res_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_idx_in    = rsp_idx_ff;
      ram_port.we    = 1'b0;
      ram_port.waddr = slot_ff;
      ram_port.wdata = {key_ff, val_ff};
      ram_port.raddr = slot_ff;

      unique case (state_ff)
         S_IDLE: begin
            ram_port.raddr = req_home;
            if (req_valid) begin
               op_in   = req_type;
               key_in  = req_key;
               val_in  = req_value;
               home_in = req_home;
               slot_in = req_home;
               cnt_in  = '0;
               unique case (req_type)
                  REQ_INSERT: state_in = S_ICHK;
                  REQ_SEARCH, REQ_DELETE: state_in = S_SRCH;
                  default: begin
                     res_status_in = STATUS_MISS;
                     res_value_in  = '0;
                     res_idx_in    = '0;
                     state_in      = S_RESP;
                  end
               endcase
            end
         end
         S_ICHK: begin
            // home entry is on the read port now
            cnt_in   = '0;
            state_in = S_FREE;
            if (replace_mode && used_ff[home_ff] && rd_home != home_ff) begin
               ram_port.we    = 1'b1;
               ram_port.waddr = home_ff;
               key_in  = rd_key;
               val_in  = rd_val;
               slot_in = next_slot(home_ff);
               disp_in = 1'b1;
            end else begin
               slot_in = home_ff;
               disp_in = 1'b0;
            end
         end
         S_FREE: begin
            if (!used_ff[slot_ff]) begin
               ram_port.we       = 1'b1;
               ram_port.waddr    = slot_ff;
               used_in[slot_ff]  = 1'b1;
               res_status_in     = STATUS_DONE;
               res_value_in      = '0;
               res_idx_in        = disp_ff ? home_ff : slot_ff;
               state_in          = S_RESP;
            end else if (cnt_ff == (disp_ff ? DISP_LAST : LAST_SLOT)) begin
               res_status_in = STATUS_FULL;
               res_value_in  = '0;
               res_idx_in    = disp_ff ? home_ff : '0;
               state_in      = S_RESP;
            end else begin
               slot_in = next_slot(slot_ff);
               cnt_in  = slot_type'(cnt_ff + 1'b1);
            end
         end
         S_SRCH: begin
            // read issued here is compared in the following cycle
            cmp_valid_in = issuing;
            cmp_slot_in  = slot_ff;
            cmp_used_in  = used_ff[slot_ff];
            cmp_last_in  = (cnt_ff == LAST_SLOT);
            if (issuing) begin
               slot_in = next_slot(slot_ff);
               cnt_in  = slot_type'(cnt_ff + 1'b1);
            end
            if (cmp_valid_ff && cmp_used_ff && rd_key == key_ff) begin
               res_status_in = STATUS_DONE;
               res_idx_in    = cmp_slot_ff;
               res_value_in  = (op_ff == REQ_SEARCH) ? rd_val : '0;
               if (op_ff == REQ_DELETE) begin
                  used_in[cmp_slot_ff] = 1'b0;
               end
               cmp_valid_in = 1'b0;
               state_in     = S_RESP;
            end else if (cmp_valid_ff && cmp_last_ff) begin
               res_status_in = STATUS_MISS;
               res_idx_in    = '0;
               res_value_in  = '0;
               cmp_valid_in  = 1'b0;
               state_in      = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_idx_in    = res_idx_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      home_ff       <= home_in;
      slot_ff       <= slot_in;
      cnt_ff        <= cnt_in;
      disp_ff       <= disp_in;
      cmp_slot_ff   <= cmp_slot_in;
      cmp_used_ff   <= cmp_used_in;
      cmp_last_ff   <= cmp_last_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_idx_ff    <= res_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_idx_ff    <= rsp_idx_in;
   end

endmodule
`default_nettype wire

### sv/linear_probe_hash_dictionary_top.sv
// Top level of the linear-probe dictionary: register port, entry RAM and probe sequencer.
//
// Usage:
//  - req channel (valid/ready): one beat carries req_type (insert, search,
//    delete), req_key and req_value. Home = key's first letter, else top byte mod 26.
//  - rsp channel (valid/ready): exactly one beat per request with
//    rsp_status, rsp_found_value and rsp_slot_index.
//  - csr port (APB style, pready tied high): register 0 at byte 0 holds
//    replace_mode. Write only while no request is in flight.
//  - Keys and values live in one 26 x 128 RAM with a registered read; the
//    occupancy bits are flip-flops cleared by reset.
//  - Insert reads the home slot from RAM, then probes the occupancy bits
//    slot by slot for a free one; search/delete issue one RAM read per
//    probed slot, each compare overlapped with the next read. An unused
//    request code answers MISS without any probe.
//  - One request at a time; the free-slot probe or the key probe over the
//    RAM read port sets the rate.
//  - The result sits in an output register; a new request is accepted
//    while it waits. A stalled receiver holds the next result inside.
//  - Reset (synchronous, active high): table empty, replace_mode 0,
//    no result pending.
`default_nettype none
module linear_probe_hash_dictionary_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [1:0]                         req_type,
   input  wire logic [lphd_pkg::KEY_BITS-1:0]      req_key,
   input  wire logic [lphd_pkg::VALUE_BITS-1:0]    req_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [1:0]                              rsp_status,
   output logic [lphd_pkg::VALUE_BITS-1:0]         rsp_found_value,
   output logic [lphd_pkg::SLOT_BITS-1:0]          rsp_slot_index,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [lphd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [lphd_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [lphd_pkg::CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                                    csr_pready
);
   import lphd_pkg::*;

   logic                  replace_mode_ff, replace_mode_in;
   logic                  csr_hit;
   ram_port_type          ram_port;
   logic [ENTRY_BITS-1:0] ram_rdata;

   // Register decode: byte addresses 0..3 select replace_mode, the rest
   // of the space reads zero and ignores writes.
   assign csr_hit    = (csr_paddr[CSR_ADDR_BITS-1] == 1'b0);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_BITS'(replace_mode_ff) : '0;

   always_comb begin
      replace_mode_in = replace_mode_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         replace_mode_in = csr_pwdata[CSR_REPLACE_MODE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         replace_mode_ff <= 1'b0;
      end else begin
         replace_mode_ff <= replace_mode_in;
      end
   end

   // key in the upper half of an entry, value in the lower half
   lphd_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (SLOT_COUNT)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_port.we),
      .waddr (ram_port.waddr),
      .wdata (ram_port.wdata),
      .raddr (ram_port.raddr),
      .rdata (ram_rdata)
   );

   lphd_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .replace_mode    (replace_mode_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value),
      .rsp_slot_index  (rsp_slot_index),
      .ram_port        (ram_port),
      .ram_rdata       (ram_rdata)
   );

endmodule
`default_nettype wire
